@@ hw/rtl/tun_pkg.sv @@
package tun_pkg;

	localparam int COORD_W          = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_W         = 16;
	localparam int DIFF_W           = COORD_W + 1;
	localparam int PROD_W           = 2 * DIFF_W;
	localparam int CROSS_W          = PROD_W + 1;
	localparam int MAG_W            = PROD_W;
	localparam int HALF_W           = MAG_W / 2;
	localparam int SQ_W             = 2 * MAG_W;
	localparam int REM_W            = SQ_W + 2 * NORMAL_FRAC_BITS + 2;
	localparam int Q_W              = NORMAL_FRAC_BITS + 1;
	localparam int NUM_CELLS        = Q_W;
	localparam int NUM_AXES         = 3;

	// One item as it travels down the row of root cells.
	typedef struct packed {
		logic                                valid;
		logic                                degen;
		logic [NUM_AXES-1:0]                 neg;
		logic [REM_W-1:0]                    d;
		logic [NUM_AXES-1:0][REM_W-1:0]      r;
		logic [NUM_AXES-1:0][REM_W-1:0]      e;
		logic [NUM_AXES-1:0][Q_W-1:0]        q;
	} cell_t;

endpackage

@@ hw/rtl/tun_front.sv @@
module tun_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic signed [tun_pkg::COORD_W-1:0] a_x,
	input  logic signed [tun_pkg::COORD_W-1:0] a_y,
	input  logic signed [tun_pkg::COORD_W-1:0] a_z,
	input  logic signed [tun_pkg::COORD_W-1:0] b_x,
	input  logic signed [tun_pkg::COORD_W-1:0] b_y,
	input  logic signed [tun_pkg::COORD_W-1:0] b_z,
	input  logic signed [tun_pkg::COORD_W-1:0] c_x,
	input  logic signed [tun_pkg::COORD_W-1:0] c_y,
	input  logic signed [tun_pkg::COORD_W-1:0] c_z,
	output tun_pkg::cell_t                     dout
);

	localparam int AX = tun_pkg::NUM_AXES;

	logic [6:0] valid_q;

	logic signed [tun_pkg::DIFF_W-1:0]  d1_s1 [AX];
	logic signed [tun_pkg::DIFF_W-1:0]  d2_s1 [AX];
	logic signed [tun_pkg::PROD_W-1:0]  m1_s2 [AX];
	logic signed [tun_pkg::PROD_W-1:0]  m2_s2 [AX];
	logic signed [tun_pkg::CROSS_W-1:0] cross_s3 [AX];
	logic [tun_pkg::MAG_W-1:0]          mag_s4 [AX];
	logic [AX-1:0]                      neg_s4, neg_s5, neg_s6;
	logic                               degen_s4, degen_s5, degen_s6;
	logic [2*tun_pkg::HALF_W-1:0]       hh_s5 [AX];
	logic [2*tun_pkg::HALF_W-1:0]       hl_s5 [AX];
	logic [2*tun_pkg::HALF_W-1:0]       ll_s5 [AX];
	logic [tun_pkg::SQ_W-1:0]           sq_s6 [AX];
	logic [tun_pkg::SQ_W-1:0]           len2;
	logic signed [tun_pkg::COORD_W-1:0] pa [AX];
	logic signed [tun_pkg::COORD_W-1:0] pb [AX];
	logic signed [tun_pkg::COORD_W-1:0] pc [AX];
	logic signed [tun_pkg::CROSS_W-1:0] neg_cross [AX];
	tun_pkg::cell_t                     init;
	tun_pkg::cell_t                     dout_s7;

	assign pa[0] = a_x; assign pa[1] = a_y; assign pa[2] = a_z;
	assign pb[0] = b_x; assign pb[1] = b_y; assign pb[2] = b_z;
	assign pc[0] = c_x; assign pc[1] = c_y; assign pc[2] = c_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[5:0], in_valid};
		end
	end

	always_comb begin
		for (int i = 0; i < AX; i++) begin
			neg_cross[i] = -cross_s3[i];
		end
		len2 = sq_s6[0] + sq_s6[1] + sq_s6[2];
		init       = '0;
		init.degen = degen_s6;
		init.neg   = neg_s6;
		init.d     = {{(tun_pkg::REM_W - tun_pkg::SQ_W - 2*tun_pkg::NORMAL_FRAC_BITS){1'b0}},
			len2, {(2*tun_pkg::NORMAL_FRAC_BITS){1'b0}}};
		for (int i = 0; i < AX; i++) begin
			init.r[i] = {{(tun_pkg::REM_W - tun_pkg::SQ_W - 2*tun_pkg::NORMAL_FRAC_BITS){1'b0}},
				sq_s6[i], {(2*tun_pkg::NORMAL_FRAC_BITS){1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AX; i++) begin
				d1_s1[i] <= tun_pkg::DIFF_W'(pb[i]) - tun_pkg::DIFF_W'(pa[i]);
				d2_s1[i] <= tun_pkg::DIFF_W'(pc[i]) - tun_pkg::DIFF_W'(pa[i]);
				m1_s2[i] <= d1_s1[(i + 1) % 3] * d2_s1[(i + 2) % 3];
				m2_s2[i] <= d1_s1[(i + 2) % 3] * d2_s1[(i + 1) % 3];
				cross_s3[i] <= tun_pkg::CROSS_W'(m1_s2[i]) - tun_pkg::CROSS_W'(m2_s2[i]);
				neg_s4[i] <= cross_s3[i][tun_pkg::CROSS_W-1];
				mag_s4[i] <= cross_s3[i][tun_pkg::CROSS_W-1] ?
					neg_cross[i][tun_pkg::MAG_W-1:0] : cross_s3[i][tun_pkg::MAG_W-1:0];
				// The square of the magnitude is formed from two halves.
				hh_s5[i] <= mag_s4[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W] *
					mag_s4[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W];
				hl_s5[i] <= mag_s4[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W] *
					mag_s4[i][tun_pkg::HALF_W-1:0];
				ll_s5[i] <= mag_s4[i][tun_pkg::HALF_W-1:0] * mag_s4[i][tun_pkg::HALF_W-1:0];
				sq_s6[i] <= {hh_s5[i], {(2*tun_pkg::HALF_W){1'b0}}}
					+ {{(tun_pkg::HALF_W-1){1'b0}}, hl_s5[i], {(tun_pkg::HALF_W+1){1'b0}}}
					+ {{(2*tun_pkg::HALF_W){1'b0}}, ll_s5[i]};
			end
			degen_s4 <= (cross_s3[0] == '0) && (cross_s3[1] == '0) && (cross_s3[2] == '0);
			neg_s5   <= neg_s4;
			neg_s6   <= neg_s5;
			degen_s5 <= degen_s4;
			degen_s6 <= degen_s5;
			dout_s7  <= init;
		end
	end

	// The valid bit comes from the reset shift register, aligned with the seventh stage.
	always_comb begin
		dout       = dout_s7;
		dout.valid = valid_q[6];
	end

endmodule

@@ hw/rtl/tun_cell.sv @@
module tun_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tun_pkg::cell_t din,
	output tun_pkg::cell_t dout_q
);

	// Each cell decides one quotient bit, most significant first. The
	// remainder r holds num - q^2 * len2 scaled; e tracks 2^(b+1) * q * len2
	// and d tracks 2^(2b) * len2, so every cell uses the same shifts.
	logic [tun_pkg::REM_W:0]   sum  [tun_pkg::NUM_AXES];
	logic [tun_pkg::REM_W+1:0] diff [tun_pkg::NUM_AXES];
	logic [tun_pkg::NUM_AXES-1:0] take;
	tun_pkg::cell_t nxt;
	tun_pkg::cell_t data_q;
	logic           valid_q;

	always_comb begin
		nxt   = din;
		nxt.d = din.d >> 2;
		for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
			sum[k]  = {1'b0, din.e[k]} + {1'b0, din.d};
			diff[k] = {2'b00, din.r[k]} - {1'b0, sum[k]};
			take[k] = ~diff[k][tun_pkg::REM_W+1];
			nxt.r[k] = take[k] ? diff[k][tun_pkg::REM_W-1:0] : din.r[k];
			nxt.e[k] = take[k] ? (din.e[k] >> 1) + din.d : (din.e[k] >> 1);
			nxt.q[k] = {din.q[k][tun_pkg::Q_W-2:0], take[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		dout_q       = data_q;
		dout_q.valid = valid_q;
	end

endmodule

@@ hw/rtl/triangle_unit_normal_top.sv @@
// Unit face normal of a triangle: (B-A) x (C-A) divided by its length, each
// component in signed Q1.14 truncated toward zero, with a degenerate flag and a
// zero normal when the cross product vanishes. One triangle is taken every
// cycle unless a result sits unclaimed at the output; a result passes through
// seven front stages (differences, cross products, squares), a row of fifteen
// square-root division cells, one per quotient bit, and the output register.
module triangle_unit_normal_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tun_pkg::COORD_W-1:0]  a_x,
	input  logic signed [tun_pkg::COORD_W-1:0]  a_y,
	input  logic signed [tun_pkg::COORD_W-1:0]  a_z,
	input  logic signed [tun_pkg::COORD_W-1:0]  b_x,
	input  logic signed [tun_pkg::COORD_W-1:0]  b_y,
	input  logic signed [tun_pkg::COORD_W-1:0]  b_z,
	input  logic signed [tun_pkg::COORD_W-1:0]  c_x,
	input  logic signed [tun_pkg::COORD_W-1:0]  c_y,
	input  logic signed [tun_pkg::COORD_W-1:0]  c_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tun_pkg::NORMAL_W-1:0] normal_x,
	output logic signed [tun_pkg::NORMAL_W-1:0] normal_y,
	output logic signed [tun_pkg::NORMAL_W-1:0] normal_z,
	output logic                                degenerate
);

	localparam int NW = tun_pkg::NORMAL_W;

	logic                en;
	tun_pkg::cell_t      chain [tun_pkg::NUM_CELLS+1];
	tun_pkg::cell_t      last;
	logic                out_valid_q;
	logic [NW-1:0]       comp [tun_pkg::NUM_AXES];
	logic [NW-1:0]       mag  [tun_pkg::NUM_AXES];

	// The whole pipeline advances unless a result sits unclaimed at the output.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	tun_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.dout(chain[0])
	);

	for (genvar g = 0; g < tun_pkg::NUM_CELLS; g++) begin : g_cell
		tun_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.din(chain[g]), .dout_q(chain[g+1])
		);
	end

	assign last = chain[tun_pkg::NUM_CELLS];

	always_comb begin
		for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
			mag[k]  = NW'(last.q[k]);
			comp[k] = last.degen ? '0 : (last.neg[k] ? -mag[k] : mag[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			normal_x   <= comp[0];
			normal_y   <= comp[1];
			normal_z   <= comp[2];
			degenerate <= last.degen;
		end
	end

	assign out_valid = out_valid_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("degenerate result carries a nonzero normal");

	a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !degenerate) |-> !(normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("nondegenerate result has a zero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
			normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
			normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
		else $error("normal component beyond unit length");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(normal_x) && $stable(degenerate)))
		else $error("stalled result changed");

endmodule
